>>> sv/dnnp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnnp_pkg
// shared types and constants for the dotted network number parser
// ----------------------------------------------------------------------------
package dnnp_pkg;

  localparam int unsigned MAX_PARTS = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [8:0] PART_MAX = 9'h0ff;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_OCT = 2'd1,
    RAD_HEX = 2'd2
  } radix_t;

endpackage : dnnp_pkg
`default_nettype wire

>>> sv/dotted_network_number_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dotted_network_number_parser
// parses a dotted network number one character per request
//
//   channel  dir  fields
//   s_*      in   s_tdata[7:0] = char_in
//   m_*      out  m_tdata[31:0] = net_value, m_tuser[0] = bad_string
//
// one character per cycle unless a nul waits on a stalled result; a request
// is held in the input register and parsed on the way into the parse state
// and the result register; a nul character puts one result on m_*
// reset clears the parse state and both valid flags
// a stalled result holds only a nul in the input register; other characters
// keep flowing while the result waits
// ----------------------------------------------------------------------------
module dotted_network_number_parser
  import dnnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] net_value
  output logic             m_tuser    // [0] bad_string
);

  logic       in_valid;
  logic [7:0] in_char;

  phase_t      phase, phase_next;
  radix_t      radix_mode, radix_mode_next;
  logic [8:0]  part_value, part_value_next;
  logic        part_too_big, part_too_big_next;
  logic        saw_digit, saw_digit_next;
  logic [2:0]  parts_done, parts_done_next;
  logic [31:0] packed_parts, packed_parts_next;
  logic        error_seen, error_seen_next;

  logic        is_nul, is_x, is_space, is_dec, is_hex_letter, active, proc;
  logic [7:0]  low_char;
  logic [3:0]  digit;
  logic [11:0] scaled, sum;

  assign is_nul  = (in_char == CH_NUL);
  assign proc    = in_valid && (!is_nul || !m_tvalid || m_tready);
  assign s_tready = !in_valid || proc;

  assign low_char      = in_char | CASE_BIT;
  assign is_x          = (in_char == CH_LOW_X) || (in_char == CH_UP_X);
  assign is_space      = (in_char == CH_SPACE) || ((in_char >= CH_TAB) && (in_char <= CH_CR));
  assign is_dec        = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign is_hex_letter = (radix_mode == RAD_HEX) && (low_char >= CH_LOW_A) &&
                         (low_char <= CH_LOW_F);
  assign active        = !error_seen && (phase != PH_DONE);
  assign digit         = is_dec ? 4'(in_char - CH_ZERO) : 4'(low_char - CH_LOW_A + 8'd10);

  always_comb begin
    case (radix_mode)
      RAD_HEX: scaled = {part_value[7:0], 4'b0};
      RAD_OCT: scaled = {1'b0, part_value[7:0], 3'b0};
      default: scaled = {1'b0, part_value[7:0], 3'b0} + {3'b0, part_value[7:0], 1'b0};
    endcase
  end

  assign sum = scaled + {8'b0, digit};

  always_comb begin
    phase_next        = phase;
    radix_mode_next   = radix_mode;
    part_value_next   = part_value;
    part_too_big_next = part_too_big;
    saw_digit_next    = saw_digit;
    parts_done_next   = parts_done;
    packed_parts_next = packed_parts;
    error_seen_next   = error_seen;
    if (active) begin
      if ((phase == PH_START) && (in_char == CH_ZERO)) begin
        saw_digit_next  = 1'b1;
        radix_mode_next = RAD_OCT;
        phase_next      = PH_ZERO;
      end else if (((phase == PH_START) || (phase == PH_ZERO)) && is_x) begin
        radix_mode_next = RAD_HEX;
        phase_next      = PH_DIGITS;
      end else begin
        phase_next = PH_DIGITS;
        if (is_dec && (radix_mode == RAD_OCT) && (in_char >= CH_EIGHT)) begin
          error_seen_next = 1'b1;
        end else if (is_dec || is_hex_letter) begin
          if (!part_too_big) begin
            part_value_next = sum[8:0];
            if (sum > {3'b0, PART_MAX}) begin
              part_too_big_next = 1'b1;
            end
          end
          saw_digit_next = 1'b1;
        end else if (!saw_digit || (parts_done >= 3'(MAX_PARTS)) || part_too_big ||
                     !(is_nul || (in_char == CH_DOT) || is_space)) begin
          error_seen_next = 1'b1;
        end else begin
          packed_parts_next = {packed_parts[23:0], part_value[7:0]};
          parts_done_next   = parts_done + 3'd1;
          if (in_char == CH_DOT) begin
            phase_next        = PH_START;
            radix_mode_next   = RAD_DEC;
            part_value_next   = '0;
            part_too_big_next = 1'b0;
            saw_digit_next    = 1'b0;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (proc && is_nul)) begin
      phase        <= PH_START;
      radix_mode   <= RAD_DEC;
      part_value   <= '0;
      part_too_big <= 1'b0;
      saw_digit    <= 1'b0;
      parts_done   <= '0;
      packed_parts <= '0;
      error_seen   <= 1'b0;
    end else if (proc) begin
      phase        <= phase_next;
      radix_mode   <= radix_mode_next;
      part_value   <= part_value_next;
      part_too_big <= part_too_big_next;
      saw_digit    <= saw_digit_next;
      parts_done   <= parts_done_next;
      packed_parts <= packed_parts_next;
      error_seen   <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc && is_nul) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_nul) begin
      m_tdata <= error_seen_next ? '1 : packed_parts_next;
      m_tuser <= error_seen_next;
    end
  end

  // error results always carry all ones
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> (m_tdata == '1))
    else $error("error result without all-ones value");

  assert property (@(posedge clk) disable iff (rst) parts_done <= 3'(MAX_PARTS))
    else $error("part count beyond limit");

  assert property (@(posedge clk) disable iff (rst) (phase == PH_DONE) |-> !error_seen)
    else $error("closed number with error flag");

  assert property (@(posedge clk) disable iff (rst)
                   (proc && is_nul) |=> (parts_done == '0) && !error_seen && m_tvalid)
    else $error("end of string did not clear state or raise result");

endmodule : dotted_network_number_parser
`default_nettype wire
